// ----- hdl/alpd_pkg.sv -----
// ----------------------------------------------------------------------------
// alpd_pkg
// Shared types and constants for the ASCII length-prefixed deframer.
// ----------------------------------------------------------------------------
package alpd_pkg;

  // width of the internal length and byte counters
  localparam int unsigned LENGTH_BITS = 16;

  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned OUTLEN_W = 16;
  localparam int unsigned MAXLEN_W = 16;
  localparam int unsigned KIND_W   = 2;

  // room for length*10 + digit
  localparam int unsigned NEXT_W = LENGTH_BITS + 4;
  localparam int unsigned CMP_W  = (NEXT_W > MAXLEN_W) ? NEXT_W : MAXLEN_W;

  localparam logic [MAXLEN_W-1:0] MAX_LENGTH_RST = 16'hFFFF;

  localparam logic [BYTE_W-1:0] SPACE_CODE = 8'h20;
  localparam logic [BYTE_W-1:0] DIGIT_ZERO = 8'd48;
  localparam logic [BYTE_W-1:0] DIGIT_NINE = 8'd57;
  localparam logic [BYTE_W-1:0] TERMINATOR = 8'h00;

  typedef enum logic [KIND_W-1:0] {
    KIND_PAYLOAD = 2'd0,
    KIND_ACCEPT  = 2'd1,
    KIND_REJECT  = 2'd2
  } alpd_kind_e;

  typedef struct packed {
    alpd_kind_e            kind;
    logic [BYTE_W-1:0]     data;
    logic [OUTLEN_W-1:0]   length;
  } alpd_result_t;

endpackage

// ----- hdl/alpd_rx_if.sv -----
// ----------------------------------------------------------------------------
// alpd_rx_if
// Received byte channel, valid/ready.
// ----------------------------------------------------------------------------
interface alpd_rx_if;
  logic                        valid;
  logic                        ready;
  logic [alpd_pkg::BYTE_W-1:0] rx_byte;

  modport source (output valid, output rx_byte, input ready);
  modport sink   (input valid, input rx_byte, output ready);
endinterface

// ----- hdl/alpd_cfg_if.sv -----
// ----------------------------------------------------------------------------
// alpd_cfg_if
// Configuration write channel for the max_length register.
// ----------------------------------------------------------------------------
interface alpd_cfg_if;
  logic                          valid;
  logic                          ready;
  logic [alpd_pkg::MAXLEN_W-1:0] max_length;

  modport source (output valid, output max_length, input ready);
  modport sink   (input valid, input max_length, output ready);
endinterface

// ----- hdl/alpd_res_if.sv -----
// ----------------------------------------------------------------------------
// alpd_res_if
// Result channel: payload bytes and frame verdicts, valid/ready.
// ----------------------------------------------------------------------------
interface alpd_res_if;
  logic                          valid;
  logic                          ready;
  logic [alpd_pkg::KIND_W-1:0]   out_kind;
  logic [alpd_pkg::BYTE_W-1:0]   out_byte;
  logic [alpd_pkg::OUTLEN_W-1:0] out_length;

  modport source (output valid, output out_kind, output out_byte, output out_length,
                  input ready);
  modport sink   (input valid, input out_kind, input out_byte, input out_length,
                  output ready);
endinterface

// ----- hdl/alpd_parser.sv -----
// ----------------------------------------------------------------------------
// alpd_parser
// Input byte register, header/payload state and per-byte result logic.
// ----------------------------------------------------------------------------
module alpd_parser (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  alpd_rx_if.sink                rx,
  alpd_cfg_if.sink               cfg,
  output logic                   res_valid_o,
  output alpd_pkg::alpd_result_t res_o,
  input  logic                   res_ready_i
);

  localparam int unsigned LB = alpd_pkg::LENGTH_BITS;
  localparam int unsigned NW = alpd_pkg::NEXT_W;
  localparam int unsigned CW = alpd_pkg::CMP_W;

  logic                            in_valid_q;
  logic [alpd_pkg::BYTE_W-1:0]     in_byte_q;
  logic                            in_header_q, in_header_d;
  logic [LB-1:0]                   len_q, len_d;
  logic [LB-1:0]                   cnt_q, cnt_d;
  logic [alpd_pkg::MAXLEN_W-1:0]   max_len_q;

  logic                            in_fire;
  logic                            has_result;
  logic                            is_digit;
  logic [alpd_pkg::BYTE_W-1:0]     digit_full;
  logic [NW-1:0]                   len_ext;
  logic [NW-1:0]                   next_len;
  logic                            too_large;
  logic [LB+alpd_pkg::OUTLEN_W-1:0] len_wide;

  assign cfg.ready = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      max_len_q <= alpd_pkg::MAX_LENGTH_RST;
    end else if (cfg.valid) begin
      max_len_q <= cfg.max_length;
    end
  end

  // header bytes retire without a result, so they never wait on the output
  assign has_result = in_valid_q && !in_header_q;
  assign in_fire    = in_valid_q && (!has_result || res_ready_i);
  assign rx.ready   = !in_valid_q || in_fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (rx.ready) begin
      in_valid_q <= rx.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rx.ready && rx.valid) begin
      in_byte_q <= rx.rx_byte;
    end
  end

  // length*10 + digit as two shifts and adds
  assign digit_full = in_byte_q - alpd_pkg::DIGIT_ZERO;
  assign is_digit   = (in_byte_q >= alpd_pkg::DIGIT_ZERO) &&
                      (in_byte_q <= alpd_pkg::DIGIT_NINE);
  assign len_ext    = NW'(len_q);
  assign next_len   = (len_ext << 3) + (len_ext << 1) + NW'(digit_full[3:0]);
  assign too_large  = (next_len[NW-1:LB] != '0) ||
                      (CW'(next_len) > CW'(max_len_q));

  always_comb begin
    in_header_d = in_header_q;
    len_d       = len_q;
    cnt_d       = cnt_q;
    if (in_header_q) begin
      if ((in_byte_q == alpd_pkg::SPACE_CODE) && (len_q != '0)) begin
        in_header_d = 1'b0;
        cnt_d       = '0;
      end else if (is_digit) begin
        len_d = too_large ? '0 : next_len[LB-1:0];
      end else begin
        len_d = '0;
      end
    end else if (cnt_q < len_q) begin
      cnt_d = cnt_q + 1'b1;
    end else begin
      in_header_d = 1'b1;
      len_d       = '0;
      cnt_d       = '0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_header_q <= 1'b1;
      len_q       <= '0;
      cnt_q       <= '0;
    end else if (in_fire) begin
      in_header_q <= in_header_d;
      len_q       <= len_d;
      cnt_q       <= cnt_d;
    end
  end

  assign len_wide = {{alpd_pkg::OUTLEN_W{1'b0}}, len_q};

  always_comb begin
    res_o.length = len_wide[alpd_pkg::OUTLEN_W-1:0];
    if (cnt_q < len_q) begin
      res_o.kind = alpd_pkg::KIND_PAYLOAD;
      res_o.data = in_byte_q;
    end else begin
      if (in_byte_q == alpd_pkg::TERMINATOR) begin
        res_o.kind = alpd_pkg::KIND_ACCEPT;
      end else begin
        res_o.kind = alpd_pkg::KIND_REJECT;
      end
      res_o.data = '0;
    end
  end

  assign res_valid_o = has_result;

endmodule

// ----- hdl/alpd_out_stage.sv -----
// ----------------------------------------------------------------------------
// alpd_out_stage
// Result register that drives the output channel.
// ----------------------------------------------------------------------------
module alpd_out_stage (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   res_valid_i,
  input  alpd_pkg::alpd_result_t res_i,
  output logic                   res_ready_o,
  alpd_res_if.source             res
);

  logic                   out_valid_q;
  alpd_pkg::alpd_result_t out_q;

  // slot frees up in the same cycle the sink takes the word
  assign res_ready_o = !out_valid_q || res.ready;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_ready_o) begin
      out_valid_q <= res_valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_ready_o && res_valid_i) begin
      out_q <= res_i;
    end
  end

  assign res.valid      = out_valid_q;
  assign res.out_kind   = out_q.kind;
  assign res.out_byte   = out_q.data;
  assign res.out_length = out_q.length;

endmodule

// ----- hdl/ascii_length_prefixed_deframer_core.sv -----
// ----------------------------------------------------------------------------
// ascii_length_prefixed_deframer_core
// Recovers "<decimal length><space><payload><zero byte>" frames from a byte
// stream.
// ----------------------------------------------------------------------------
// One received byte per cycle is accepted, sustained, as long as the result
// sink keeps up; a byte is registered in the input register, decoded there
// against the header/payload state, and its result is then registered in the
// output register of alpd_out_stage, which drives the result channel. Header bytes
// produce no word and keep flowing even while the output is stalled. Each
// payload byte gives one word of kind 0; the byte after the payload gives a
// verdict word, kind 1 for a zero byte (accept) and kind 2 otherwise (reject),
// and rejected payload is left for the downstream stage to drop. out_length
// is the declared length of the frame. max_length may be written only while
// the block is idle.
module ascii_length_prefixed_deframer_core (
  input  logic       clk_i,
  input  logic       rst_ni,
  alpd_rx_if.sink    rx,
  alpd_cfg_if.sink   cfg,
  alpd_res_if.source res
);

  logic                   res_valid;
  logic                   res_ready;
  alpd_pkg::alpd_result_t res_word;

  alpd_parser u_parser (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .rx          (rx),
    .cfg         (cfg),
    .res_valid_o (res_valid),
    .res_o       (res_word),
    .res_ready_i (res_ready)
  );

  alpd_out_stage u_out_stage (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .res_valid_i (res_valid),
    .res_i       (res_word),
    .res_ready_o (res_ready),
    .res         (res)
  );

endmodule

// ----- tb/ascii_length_prefixed_deframer_core_tb.sv -----
// ----------------------------------------------------------------------------
// ascii_length_prefixed_deframer_core_tb
// Self-checking bench for the length-prefixed frame parser: a byte-level
// predictor tracks header/payload state for every accepted byte, and each
// result word is compared field by field against the oldest predicted word.
// ----------------------------------------------------------------------------
module ascii_length_prefixed_deframer_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  import alpd_pkg::*;

  localparam int unsigned    CYCLE_LIMIT  = 1_000_000;
  localparam int unsigned    SETTLE_CYC   = 4;
  localparam int unsigned    RADIX        = 10;
  localparam longint unsigned LEN_MASK    = (64'd1 << LENGTH_BITS) - 64'd1;
  localparam int unsigned    PHASE_ITEMS  = 120;
  localparam int unsigned    HOLD_CYC     = 300;

  typedef enum logic [1:0] {
    SINK_FREE,
    SINK_PERIODIC,
    SINK_RANDOM,
    SINK_LIGHT
  } sink_mode_e;

  logic clk;
  logic rst_n;

  alpd_rx_if  rx_ch ();
  alpd_cfg_if cfg_ch ();
  alpd_res_if res_ch ();

  ascii_length_prefixed_deframer_core dut (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .rx     (rx_ch),
    .cfg    (cfg_ch),
    .res    (res_ch)
  );

  // predictor state
  logic                   hdr_mode;
  logic [LENGTH_BITS-1:0] frame_len;
  logic [LENGTH_BITS-1:0] payload_seen;
  logic [MAXLEN_W-1:0]    max_len_cfg;

  alpd_result_t expected_words[$];

  int unsigned fail_count;
  int unsigned bytes_sent;
  int unsigned words_checked;
  int unsigned frames_accepted;
  int unsigned frames_rejected;
  int unsigned rx_stall_cycles;
  int unsigned cfg_writes;
  int unsigned cycle_count;

  // sender and receiver idling controls
  bit          gaps_on;
  bit          stalls_on;
  int unsigned burst_left;
  bit          hold_req;

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // ---------------------------------------------------------------------------
  // predictor
  // ---------------------------------------------------------------------------
  function automatic bit deframe_step(input logic [BYTE_W-1:0] b, output alpd_result_t w);
    longint unsigned next_len;
    w = '{KIND_PAYLOAD, '0, '0};
    if (hdr_mode) begin
      if (b == SPACE_CODE && frame_len != '0) begin
        hdr_mode     = 1'b0;
        payload_seen = '0;
      end else if (b >= DIGIT_ZERO && b <= DIGIT_NINE) begin
        next_len = longint'(frame_len) * RADIX + longint'(b - DIGIT_ZERO);
        if (next_len > longint'(max_len_cfg) || next_len > LEN_MASK) begin
          frame_len = '0;
        end else begin
          frame_len = next_len[LENGTH_BITS-1:0];
        end
      end else begin
        frame_len = '0;
      end
      return 1'b0;
    end
    w.length = OUTLEN_W'(frame_len);
    if (payload_seen < frame_len) begin
      w.kind       = KIND_PAYLOAD;
      w.data       = b;
      payload_seen = payload_seen + 1'b1;
      return 1'b1;
    end
    if (b == TERMINATOR) begin
      w.kind = KIND_ACCEPT;
    end else begin
      w.kind = KIND_REJECT;
    end
    hdr_mode  = 1'b1;
    frame_len = '0;
    payload_seen = '0;
    return 1'b1;
  endfunction

  // ---------------------------------------------------------------------------
  // result checker
  // ---------------------------------------------------------------------------
  always @(posedge clk) begin
    alpd_result_t exp_w;
    if (rst_n && res_ch.valid && res_ch.ready) begin
      if (expected_words.size() == 0) begin
        $error("unexpected word: out_kind %0d out_byte %0h out_length %0d",
               res_ch.out_kind, res_ch.out_byte, res_ch.out_length);
        fail_count++;
      end else begin
        exp_w = expected_words.pop_front();
        words_checked++;
        if (res_ch.out_kind !== exp_w.kind) begin
          $error("out_kind: expected %0d, got %0d", exp_w.kind, res_ch.out_kind);
          fail_count++;
        end
        if (res_ch.out_byte !== exp_w.data) begin
          $error("out_byte: expected %0h, got %0h", exp_w.data, res_ch.out_byte);
          fail_count++;
        end
        if (res_ch.out_length !== exp_w.length) begin
          $error("out_length: expected %0d, got %0d", exp_w.length, res_ch.out_length);
          fail_count++;
        end
        if (exp_w.kind == KIND_ACCEPT) frames_accepted++;
        if (exp_w.kind == KIND_REJECT) frames_rejected++;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // result sink: windows of free flow, periodic stalls and random stalls,
  // plus a long hold-off on request
  // ---------------------------------------------------------------------------
  initial begin
    sink_mode_e  mode;
    int unsigned window_left;
    int unsigned period;
    int unsigned phase;
    res_ch.ready = 1'b0;
    window_left  = 0;
    mode         = SINK_FREE;
    period       = 2;
    phase        = 0;
    forever begin
      @(negedge clk);
      if (hold_req) begin
        res_ch.ready <= 1'b0;
        repeat (HOLD_CYC - 1) @(negedge clk);
        hold_req = 1'b0;
      end else if (!stalls_on) begin
        res_ch.ready <= 1'b1;
      end else begin
        if (window_left == 0) begin
          mode        = sink_mode_e'($urandom_range(0, 3));
          window_left = $urandom_range(8, 48);
          period      = $urandom_range(2, 5);
          phase       = 0;
        end
        window_left--;
        case (mode)
          SINK_FREE: begin
            res_ch.ready <= 1'b1;
          end
          SINK_PERIODIC: begin
            res_ch.ready <= (phase % period) != 0;
            phase++;
          end
          SINK_RANDOM: begin
            res_ch.ready <= 1'($urandom_range(0, 1));
          end
          default: begin
            res_ch.ready <= $urandom_range(0, 3) != 0;
          end
        endcase
      end
    end
  end

  // ---------------------------------------------------------------------------
  // watchdog
  // ---------------------------------------------------------------------------
  initial begin
    cycle_count = 0;
    while (cycle_count < CYCLE_LIMIT) begin
      @(posedge clk);
      cycle_count++;
    end
    $error("timeout after %0d cycles, %0d words still expected",
           cycle_count, expected_words.size());
    $display("Simulation FAILED");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // stimulus helpers
  // ---------------------------------------------------------------------------
  task automatic send_byte(input logic [BYTE_W-1:0] b);
    alpd_result_t w;
    int unsigned  gap;
    if (gaps_on && burst_left == 0) begin
      burst_left = $urandom_range(1, 24);
      gap        = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        @(negedge clk);
        rx_ch.valid <= 1'b0;
        repeat (gap - 1) @(negedge clk);
      end
    end
    if (burst_left != 0) burst_left--;
    @(negedge clk);
    rx_ch.valid   <= 1'b1;
    rx_ch.rx_byte <= b;
    do begin
      @(posedge clk);
      if (!rx_ch.ready) rx_stall_cycles++;
    end while (!rx_ch.ready);
    if (deframe_step(b, w)) expected_words.push_back(w);
    bytes_sent++;
  endtask

  task automatic send_text(input string s);
    for (int i = 0; i < s.len(); i++) send_byte(s[i]);
  endtask

  task automatic send_number(input int unsigned n);
    send_text($sformatf("%0d", n));
  endtask

  // stop sending and let every outstanding word and header byte clear
  task automatic drain_results();
    @(negedge clk);
    rx_ch.valid <= 1'b0;
    while (expected_words.size() != 0) @(posedge clk);
    repeat (SETTLE_CYC) @(posedge clk);
  endtask

  task automatic write_max_length(input logic [MAXLEN_W-1:0] v);
    drain_results();
    @(negedge clk);
    cfg_ch.valid      <= 1'b1;
    cfg_ch.max_length <= v;
    do @(posedge clk); while (!cfg_ch.ready);
    max_len_cfg = v;
    cfg_writes++;
    @(negedge clk);
    cfg_ch.valid <= 1'b0;
  endtask

  // ---------------------------------------------------------------------------
  // tests
  // ---------------------------------------------------------------------------
  task automatic test_directed_frames();
    // accepted frame with extreme payload bytes
    send_text("3 ");
    send_byte(8'h00);
    send_byte(8'hFF);
    send_byte("A");
    send_byte(TERMINATOR);
    // rejected frame
    send_text("1 Z");
    send_byte(8'h01);
    // space on a zero length stays in the header
    send_text(" 0 ");
    // length beyond max_length falls back to zero
    send_text("65536 ");
    // a non-digit clears the partial length
    send_text("9a1 ");
    send_byte(8'h80);
    send_byte(8'h7F);
    drain_results();
  endtask

  task automatic test_max_length_extremes();
    write_max_length(16'd1);
    send_text("1 ");
    send_byte(8'h5A);
    send_byte(TERMINATOR);
    send_text("2 7");
    send_text("01 ");
    send_byte(8'hC3);
    send_byte(TERMINATOR);

    // zero max_length: every nonzero length is garbage
    write_max_length(16'd0);
    send_text("1 5");
    send_byte(TERMINATOR);
    send_text("0 ");

    write_max_length(16'd10);
    send_text("11 10 ");
    repeat (10) send_byte(8'($urandom_range(0, 255)));
    send_byte(TERMINATOR);
    drain_results();
  endtask

  task automatic test_output_backpressure();
    write_max_length(MAX_LENGTH_RST);
    gaps_on  = 1'b0;
    hold_req = 1'b1;
    send_text("120 ");
    repeat (120) send_byte(8'($urandom_range(0, 255)));
    send_byte(TERMINATOR);
    drain_results();
    while (hold_req) @(posedge clk);
    gaps_on = 1'b1;
  endtask

  task automatic test_length_limit();
    write_max_length(MAX_LENGTH_RST);
    // the largest length still fits, one more digit overflows to zero
    send_text("65535");
    send_byte("9");
    send_text("5 ");
    repeat (5) send_byte(8'($urandom_range(0, 255)));
    send_byte(8'h42);
    drain_results();
  endtask

  task automatic test_random_traffic();
    int unsigned phase_max[5];
    int unsigned start;
    int unsigned len;
    int unsigned cap;
    logic [BYTE_W-1:0] b;
    phase_max = '{12, 1, 0, 0, 65535};
    phase_max[2] = $urandom_range(2, 400);
    phase_max[3] = $urandom_range(401, 65534);
    for (int p = 0; p < 5; p++) begin
      write_max_length(MAXLEN_W'(phase_max[p]));
      start = bytes_sent;
      while (bytes_sent - start < PHASE_ITEMS) begin
        case ($urandom_range(0, 9))
          7: begin
            // oversized header
            send_number($urandom_range(max_len_cfg + 1, 999999));
            send_byte(SPACE_CODE);
          end
          8: begin
            repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)));
          end
          9: begin
            // header broken by a stray byte
            send_number($urandom_range(1, 999));
            do b = 8'($urandom_range(0, 255));
            while (b == SPACE_CODE || (b >= DIGIT_ZERO && b <= DIGIT_NINE));
            send_byte(b);
            send_byte(SPACE_CODE);
          end
          default: begin
            if (max_len_cfg != 0) begin
              cap = (max_len_cfg < 16) ? max_len_cfg : 16;
              if ($urandom_range(0, 9) == 0)
                len = (max_len_cfg <= 200) ? max_len_cfg : $urandom_range(17, 200);
              else
                len = $urandom_range(1, cap);
              if ($urandom_range(0, 3) == 0) repeat ($urandom_range(1, 2)) send_byte(DIGIT_ZERO);
              send_number(len);
              send_byte(SPACE_CODE);
              repeat (len) send_byte(8'($urandom_range(0, 255)));
              send_byte(($urandom_range(0, 3) == 0) ? 8'($urandom_range(1, 255)) : TERMINATOR);
            end
          end
        endcase
      end
    end
    drain_results();
  endtask

  // ---------------------------------------------------------------------------
  // sequence
  // ---------------------------------------------------------------------------
  initial begin
    rst_n             = 1'b0;
    rx_ch.valid       = 1'b0;
    rx_ch.rx_byte     = '0;
    cfg_ch.valid      = 1'b0;
    cfg_ch.max_length = '0;
    hdr_mode          = 1'b1;
    frame_len         = '0;
    payload_seen      = '0;
    max_len_cfg       = MAX_LENGTH_RST;
    fail_count        = 0;
    bytes_sent        = 0;
    words_checked     = 0;
    frames_accepted   = 0;
    frames_rejected   = 0;
    rx_stall_cycles   = 0;
    cfg_writes        = 0;
    gaps_on           = 1'b1;
    stalls_on         = 1'b1;
    burst_left        = 0;
    hold_req          = 1'b0;

    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    test_directed_frames();
    test_max_length_extremes();
    test_output_backpressure();
    test_length_limit();
    test_random_traffic();

    drain_results();
    repeat (8) @(posedge clk);
    if (expected_words.size() != 0) begin
      $error("%0d expected words never arrived", expected_words.size());
      fail_count++;
    end

    $display("run: %0d bytes in, %0d words checked, %0d frames accepted, %0d rejected",
             bytes_sent, words_checked, frames_accepted, frames_rejected);
    $display("run: %0d max_length writes, %0d input stall cycles, %0d mismatches",
             cfg_writes, rx_stall_cycles, fail_count);
    if (fail_count == 0) begin
      $display("Simulation PASSED");
    end else begin
      $display("Simulation FAILED");
    end
    $finish;
  end

endmodule

// ----- files.f -----
hdl/alpd_pkg.sv
hdl/alpd_rx_if.sv
hdl/alpd_cfg_if.sv
hdl/alpd_res_if.sv
hdl/alpd_parser.sv
hdl/alpd_out_stage.sv
hdl/ascii_length_prefixed_deframer_core.sv
tb/ascii_length_prefixed_deframer_core_tb.sv
